/* rtl/stq_pkg.sv */
// Shared types and constants of the speed trend qualifier.
`default_nettype none

package stq_pkg;

	localparam int COUNT_BITS_DEF = 10;
	localparam int SPEED_BITS_DEF = 24;

	// register port: widest register, register index width
	localparam int CFG_DATA_W = 10;
	localparam int CFG_IDX_W  = 3;

	// speed format
	localparam int FRAC_BITS = 8;
	localparam int WHOLE_W   = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FALL_WAIT   = 3'd0,
		REG_FALL_HOLD   = 3'd1,
		REG_RISE_WAIT   = 3'd2,
		REG_RISE_HOLD   = 3'd3,
		REG_FALL_IGN_GND = 3'd4,
		REG_RISE_IGN_GND = 3'd5,
		REG_SHOW_FALL   = 3'd6,
		REG_SHOW_RISE   = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		STYLE_NORMAL  = 2'd0,
		STYLE_FALLING = 2'd1,
		STYLE_RISING  = 2'd2
	} style_t;

	// per-direction trend inputs of one qualifier
	typedef struct packed {
		logic same;
		logic opposite;
		logic blocked;
	} dir_ctl_t;

endpackage

`default_nettype wire

/* rtl/stq_in_if.sv */
// Input channel: speed sample and ground flag.
`default_nettype none

interface stq_in_if #(
	parameter int SPEED_BITS = stq_pkg::SPEED_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [SPEED_BITS-1:0] speed;
	logic                  grounded;

	modport source (output valid, output speed, output grounded, input ready);
	modport sink   (input valid, input speed, input grounded, output ready);
endinterface

`default_nettype wire

/* rtl/stq_out_if.sv */
// Output channel: trend flags, display style and integer speed.
`default_nettype none

interface stq_out_if;
	logic                         valid;
	logic                         ready;
	logic                         falling;
	logic                         rising;
	logic [1:0]                   style;
	logic [stq_pkg::WHOLE_W-1:0]  speed_whole;

	modport source (output valid, output falling, output rising, output style,
		output speed_whole, input ready);
	modport sink   (input valid, input falling, input rising, input style,
		input speed_whole, output ready);
endinterface

`default_nettype wire

/* rtl/stq_qual.sv */
// One trend qualifier: wait, check and hold counters plus the trend flag.
`default_nettype none

module stq_qual #(
	parameter int COUNT_BITS = stq_pkg::COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  advance,
	input  wire stq_pkg::dir_ctl_t     ctl,
	input  wire logic [COUNT_BITS-1:0] wait_len,
	input  wire logic [COUNT_BITS-1:0] hold_len,
	output logic                       flag_next
);

	logic [COUNT_BITS-1:0] wait_q, check_q, hold_q;
	logic                  flag_q;
	logic [COUNT_BITS-1:0] wait_d, check_d, hold_d;
	logic                  flag_d;

	// rules applied in order, each seeing the previous one's result
	always_comb begin
		wait_d  = wait_q;
		check_d = check_q;
		hold_d  = hold_q;
		flag_d  = flag_q;
		if (ctl.same && hold_d != '0)
			hold_d = hold_len;
		if (ctl.same && wait_d == '0 && check_d == '0 && hold_d == '0 && !ctl.blocked)
			wait_d = wait_len;
		if (ctl.opposite) begin
			flag_d  = 1'b0;
			wait_d  = '0;
			check_d = '0;
			hold_d  = '0;
		end
		if (wait_d != '0) begin
			wait_d = wait_d - 1'b1;
			if (wait_d == '0)
				check_d = wait_len;
		end
		if (check_d != '0) begin
			check_d = check_d - 1'b1;
			if (ctl.same) begin
				flag_d = 1'b1;
				hold_d = hold_len;
			end
		end
		if (hold_d != '0) begin
			hold_d = hold_d - 1'b1;
			if (hold_d == '0)
				flag_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q  <= '0;
			check_q <= '0;
			hold_q  <= '0;
			flag_q  <= 1'b0;
		end else if (advance) begin
			wait_q  <= wait_d;
			check_q <= check_d;
			hold_q  <= hold_d;
			flag_q  <= flag_d;
		end
	end

	assign flag_next = flag_d;

endmodule

`default_nettype wire

/* rtl/speed_trend_qualifier_core.sv */
// Top level of the speed trend qualifier: register port, stages, both qualifiers.
`default_nettype none

// Speed trend qualifier. Each input item is a speed sample (unsigned, 8 fraction
// bits) with an on-ground flag; each item yields exactly one result item with
// the falling and rising trend flags after that frame, a display style code
// (falling shown wins over rising shown) and the integer part of the speed.
// The block takes each item through the input stage and the result register:
// a sample is captured in the input stage; when the result register is free or
// being emptied, it is compared with the previous sample, both qualifiers are
// updated and the result register is loaded, which then holds the result item.
// Throughput is one item per cycle while the sink keeps ready
// high; the result register is the only point that stalls, and the input
// stage keeps taking items whenever the result register is free or is being
// emptied in the same cycle. The first sample after reset only records the
// speed. Registers are written through cfg_we/cfg_index/cfg_data and must only
// change while no item is in flight; all reset to zero.
module speed_trend_qualifier_core #(
	parameter int COUNT_BITS = stq_pkg::COUNT_BITS_DEF,
	parameter int SPEED_BITS = stq_pkg::SPEED_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [stq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [stq_pkg::CFG_DATA_W-1:0]    cfg_data,
	stq_in_if.sink                                 in_ch,
	stq_out_if.source                              out_ch
);

	localparam int WIDE_W = SPEED_BITS + stq_pkg::FRAC_BITS + stq_pkg::WHOLE_W;

	// configuration registers
	logic [stq_pkg::CFG_DATA_W-1:0] fall_wait_q, fall_hold_q, rise_wait_q, rise_hold_q;
	logic fall_ign_q, rise_ign_q, show_fall_q, show_rise_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fall_wait_q <= '0;
			fall_hold_q <= '0;
			rise_wait_q <= '0;
			rise_hold_q <= '0;
			fall_ign_q  <= 1'b0;
			rise_ign_q  <= 1'b0;
			show_fall_q <= 1'b0;
			show_rise_q <= 1'b0;
		end else if (cfg_we) begin
			case (stq_pkg::cfg_reg_t'(cfg_index))
				stq_pkg::REG_FALL_WAIT:    fall_wait_q <= cfg_data;
				stq_pkg::REG_FALL_HOLD:    fall_hold_q <= cfg_data;
				stq_pkg::REG_RISE_WAIT:    rise_wait_q <= cfg_data;
				stq_pkg::REG_RISE_HOLD:    rise_hold_q <= cfg_data;
				stq_pkg::REG_FALL_IGN_GND: fall_ign_q  <= cfg_data[0];
				stq_pkg::REG_RISE_IGN_GND: rise_ign_q  <= cfg_data[0];
				stq_pkg::REG_SHOW_FALL:    show_fall_q <= cfg_data[0];
				stq_pkg::REG_SHOW_RISE:    show_rise_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage handshake
	logic valid_s1, valid_s2;
	logic s2_free, advance, in_acc;

	assign s2_free      = !valid_s2 || out_ch.ready;
	assign advance      = valid_s1 && s2_free;
	assign in_ch.ready  = !valid_s1 || s2_free;
	assign in_acc       = in_ch.valid && in_ch.ready;

	// input stage
	logic [SPEED_BITS-1:0] speed_s1;
	logic                  grounded_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ch.ready)
			valid_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			speed_s1    <= in_ch.speed;
			grounded_s1 <= in_ch.grounded;
		end
	end

	// previous sample; none seen yet means no change
	logic [SPEED_BITS-1:0] last_speed_q;
	logic                  have_last_q;
	logic                  dec, inc;

	assign dec = have_last_q && (speed_s1 < last_speed_q);
	assign inc = have_last_q && (speed_s1 > last_speed_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_speed_q <= '0;
			have_last_q  <= 1'b0;
		end else if (advance) begin
			last_speed_q <= speed_s1;
			have_last_q  <= 1'b1;
		end
	end

	// qualifiers
	stq_pkg::dir_ctl_t fall_ctl, rise_ctl;
	logic              fall_next, rise_next;

	assign fall_ctl = '{same: dec, opposite: inc, blocked: grounded_s1 && !fall_ign_q};
	assign rise_ctl = '{same: inc, opposite: dec, blocked: grounded_s1 && !rise_ign_q};

	stq_qual #(.COUNT_BITS(COUNT_BITS)) u_fall (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.ctl       (fall_ctl),
		.wait_len  (COUNT_BITS'(fall_wait_q)),
		.hold_len  (COUNT_BITS'(fall_hold_q)),
		.flag_next (fall_next)
	);

	stq_qual #(.COUNT_BITS(COUNT_BITS)) u_rise (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.ctl       (rise_ctl),
		.wait_len  (COUNT_BITS'(rise_wait_q)),
		.hold_len  (COUNT_BITS'(rise_hold_q)),
		.flag_next (rise_next)
	);

	// display style, falling first
	stq_pkg::style_t style_d;

	always_comb begin
		if (show_fall_q && fall_next)
			style_d = stq_pkg::STYLE_FALLING;
		else if (show_rise_q && rise_next)
			style_d = stq_pkg::STYLE_RISING;
		else
			style_d = stq_pkg::STYLE_NORMAL;
	end

	// integer part; zero-extended so narrow speeds still fill the field
	logic [WIDE_W-1:0] speed_wide;
	assign speed_wide = WIDE_W'(speed_s1);

	// result register
	logic                         falling_s2, rising_s2;
	stq_pkg::style_t              style_s2;
	logic [stq_pkg::WHOLE_W-1:0]  whole_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (s2_free)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			falling_s2 <= fall_next;
			rising_s2  <= rise_next;
			style_s2   <= style_d;
			whole_s2   <= speed_wide[stq_pkg::FRAC_BITS +: stq_pkg::WHOLE_W];
		end
	end

	assign out_ch.valid       = valid_s2;
	assign out_ch.falling     = falling_s2;
	assign out_ch.rising      = rising_s2;
	assign out_ch.style       = style_s2;
	assign out_ch.speed_whole = whole_s2;

endmodule

`default_nettype wire
